// ===== rtl/skt_pkg.sv =====
// Package of shared constants and types for the sorted key table engine.
package skt_pkg;

   localparam int Depth     = 512;
   localparam int IdxW      = 10;
   localparam int AddrW     = 9;
   localparam int KeyW      = 16;
   localparam int EntryW    = 49;
   localparam logic [15:0] DiskNil   = 16'hFFFF;
   localparam logic [15:0] RecordNil = 16'hFFFF;

   typedef enum logic [2:0] {
      FUNC_SEARCH = 3'd0,
      FUNC_GAP    = 3'd1,
      FUNC_REMOVE = 3'd2,
      FUNC_EMPTY  = 3'd3,
      FUNC_WRITE  = 3'd4
   } func_type;

   // Memory access request from the sequencer to the entry memory.
   typedef struct packed {
      logic              rd_en;
      logic [AddrW-1:0]  rd_addr;
      logic              wr_en;
      logic [AddrW-1:0]  wr_addr;
      logic [EntryW-1:0] wr_data;
   } mem_req_type;

endpackage

// ===== rtl/sorted_key_table_engine.sv =====
// Top level of the sorted key table engine: handshakes and result register.
//
// The table sits in a 512-entry memory with a registered read port and one
// item is processed at a time. A write, a refused gap, an unused function or
// a search of an empty table goes straight to the result; a search makes at
// most ten probes on a full table; opening a gap or removing a range moves
// entries one at a time, and an empty check reads and checks its entry
// before it moves any. The result waits in an output register, and the next
// request transfer is taken only when no result is pending or the pending
// one is transferred in the same cycle.
module sorted_key_table_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[2:0], key[18:3], index[28:19], count[38:29], marked[39],
   // disk_link[55:40], record_link[71:56]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found[0], position[10:1], status[11], removed[12], used_count[22:13]
   output logic [23:0] rsp_tdata
);
   import skt_pkg::*;

   mem_req_type        mem_req;
   logic [EntryW-1:0]  rd_data;
   logic               busy, done, start;
   logic               res_found, res_status, res_removed;
   logic [IdxW-1:0]    res_position, res_used;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_data_ff;

   // An item is taken when the engine is free and no earlier result is blocked.
   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign start      = req_tvalid && req_tready;

   skt_entry_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   skt_sequencer u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .op_func      (req_tdata[2:0]),
      .op_key       (req_tdata[18:3]),
      .op_index     (req_tdata[28:19]),
      .op_count     (req_tdata[38:29]),
      .op_entry     ({req_tdata[18:3], req_tdata[39], req_tdata[55:40],
                      req_tdata[71:56]}),
      .busy         (busy),
      .done         (done),
      .res_found    (res_found),
      .res_position (res_position),
      .res_status   (res_status),
      .res_removed  (res_removed),
      .res_used     (res_used),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

   // Output register holding the result until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= {1'b0, res_used, res_removed, res_status, res_position, res_found};
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A result never appears while the previous one is still pending.
   assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten");

   // No new item is taken while the sequencer is working.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("request taken while busy");

   // Every finished operation leaves its result pending on the output.
   assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid)
      else $error("result lost");
endmodule

// ===== rtl/skt_entry_ram.sv =====
// Entry memory: one write port and one registered read port.
module skt_entry_ram (
   input  logic                     clock,
   input  skt_pkg::mem_req_type     mem_req,
   output logic [skt_pkg::EntryW-1:0] rd_data
);
   import skt_pkg::*;

   logic [EntryW-1:0] mem [Depth];
   logic [EntryW-1:0] rd_data_ff;

   // Synchronous write and read; the read data is registered.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/skt_sequencer.sv =====
// Sequencer that runs search, shift, check and write operations on the memory.
module skt_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2:0]                 op_func,
   input  logic [skt_pkg::KeyW-1:0]   op_key,
   input  logic [skt_pkg::IdxW-1:0]   op_index,
   input  logic [skt_pkg::IdxW-1:0]   op_count,
   input  logic [skt_pkg::EntryW-1:0] op_entry,
   output logic                       busy,
   output logic                       done,
   output logic                       res_found,
   output logic [skt_pkg::IdxW-1:0]   res_position,
   output logic                       res_status,
   output logic                       res_removed,
   output logic [skt_pkg::IdxW-1:0]   res_used,
   output skt_pkg::mem_req_type       mem_req,
   input  logic [skt_pkg::EntryW-1:0] rd_data
);
   import skt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_S_READ, ST_S_CMP, ST_G_READ, ST_G_WRITE,
      ST_R_READ, ST_R_WRITE, ST_E_READ, ST_E_CHECK, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [IdxW-1:0]    used_ff;
   logic [IdxW+1:0]    lo_ff, hi_ff;   // unsigned search bounds
   logic [IdxW-1:0]    mid_ff;
   logic               above_ff, found_ff, status_ff, removed_ff;
   logic [IdxW:0]      src_ff;          // shift source pointer
   logic [IdxW:0]      dst_ff;          // shift destination pointer
   logic [IdxW:0]      end_ff;          // shift end bound
   logic [IdxW-1:0]    pos_ff;
   logic [KeyW-1:0]    key_ff;

   logic [IdxW+1:0]    mid_sum;
   logic [IdxW:0]      at_sat, rem_n, avail, gap_total, src_prev;
   logic               key_eq, key_gt, empty_ok;

   assign mid_sum  = (lo_ff + hi_ff) >> 1;
   assign key_eq   = key_ff == rd_data[48:33];
   assign key_gt   = key_ff >  rd_data[48:33];
   assign empty_ok = !rd_data[32] && rd_data[31:16] == DiskNil
                     && rd_data[15:0] == RecordNil;
   assign at_sat   = (op_index > used_ff) ? {1'b0, used_ff} : {1'b0, op_index};
   assign avail    = {1'b0, used_ff} - at_sat;
   assign rem_n    = ({1'b0, op_count} > avail) ? avail : {1'b0, op_count};
   assign gap_total = {1'b0, used_ff} + {1'b0, op_count};
   // Opening a gap moves entries from the top down, so the entry below the pointer is read.
   assign src_prev = src_ff - 1'b1;

   // Memory requests follow the state.
   always_comb begin
      mem_req         = '0;
      mem_req.wr_data = rd_data;
      case (state_ff)
         ST_S_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = mid_sum[AddrW-1:0];
         end
         ST_G_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = src_prev[AddrW-1:0];
         end
         ST_R_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = src_ff[AddrW-1:0];
         end
         ST_E_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pos_ff[AddrW-1:0];
         end
         ST_G_WRITE, ST_R_WRITE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = dst_ff[AddrW-1:0];
         end
         ST_IDLE: begin
            mem_req.wr_en   = start && op_func == FUNC_WRITE && !op_index[IdxW-1];
            mem_req.wr_addr = op_index[AddrW-1:0];
            mem_req.wr_data = op_entry;
         end
         default: ;
      endcase
   end

   // Operation sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  found_ff <= 1'b0; status_ff <= 1'b0; removed_ff <= 1'b0;
                  mid_ff <= '0; above_ff <= 1'b0; key_ff <= op_key;
                  case (op_func)
                     FUNC_SEARCH: begin
                        lo_ff <= '0;
                        hi_ff <= {2'b00, used_ff} - 1'b1;
                        state_ff <= (used_ff == '0) ? ST_DONE : ST_S_READ;
                     end
                     FUNC_GAP: begin
                        if (gap_total > (IdxW+1)'(Depth)) begin
                           status_ff <= 1'b1;
                           state_ff  <= ST_DONE;
                        end else begin
                           src_ff   <= {1'b0, used_ff};
                           dst_ff   <= gap_total;
                           end_ff   <= at_sat;
                           used_ff  <= gap_total[IdxW-1:0];
                           state_ff <= ({1'b0, used_ff} > at_sat) ? ST_G_READ : ST_DONE;
                        end
                     end
                     FUNC_REMOVE: begin
                        dst_ff   <= at_sat;
                        src_ff   <= at_sat + rem_n;
                        end_ff   <= {1'b0, used_ff};
                        used_ff  <= used_ff - rem_n[IdxW-1:0];
                        state_ff <= (rem_n != '0 && at_sat + rem_n < {1'b0, used_ff})
                                    ? ST_R_READ : ST_DONE;
                     end
                     FUNC_EMPTY: begin
                        pos_ff   <= op_index;
                        state_ff <= (op_index < used_ff) ? ST_E_READ : ST_DONE;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_S_READ: begin
               mid_ff   <= mid_sum[IdxW-1:0];
               state_ff <= ST_S_CMP;
            end
            ST_S_CMP: begin
               above_ff <= 1'b0;
               if (key_eq) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end else if (key_gt) begin
                  above_ff <= 1'b1;
                  lo_ff    <= {2'b00, mid_ff} + 1'b1;
                  state_ff <= ({2'b00, mid_ff} + 1'b1 <= hi_ff) ? ST_S_READ : ST_DONE;
               end else begin
                  hi_ff    <= {2'b00, mid_ff} - 1'b1;
                  state_ff <= (mid_ff != '0 && {2'b00, mid_ff} - 1'b1 >= lo_ff)
                              ? ST_S_READ : ST_DONE;
               end
            end
            ST_G_READ: begin
               src_ff   <= src_ff - 1'b1;
               dst_ff   <= dst_ff - 1'b1;
               state_ff <= ST_G_WRITE;
            end
            ST_G_WRITE: begin
               state_ff <= (src_ff > end_ff) ? ST_G_READ : ST_DONE;
            end
            ST_R_READ: state_ff <= ST_R_WRITE;
            ST_R_WRITE: begin
               src_ff   <= src_ff + 1'b1;
               dst_ff   <= dst_ff + 1'b1;
               state_ff <= (src_ff + 1'b1 < end_ff) ? ST_R_READ : ST_DONE;
            end
            ST_E_READ: state_ff <= ST_E_CHECK;
            ST_E_CHECK: begin
               if (empty_ok) begin
                  removed_ff <= 1'b1;
                  dst_ff     <= {1'b0, pos_ff};
                  src_ff     <= {1'b0, pos_ff} + 1'b1;
                  end_ff     <= {1'b0, used_ff};
                  used_ff    <= used_ff - 1'b1;
                  state_ff   <= ({1'b0, pos_ff} + 1'b1 < {1'b0, used_ff})
                                ? ST_R_READ : ST_DONE;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy         = state_ff != ST_IDLE;
   assign done         = state_ff == ST_DONE;
   assign res_found    = found_ff;
   assign res_position = above_ff ? mid_ff + 1'b1 : mid_ff;
   assign res_status   = status_ff;
   assign res_removed  = removed_ff;
   assign res_used     = used_ff;
endmodule

// ===== tb/sv/sorted_key_table_engine_checker.sv =====
// Checker for the sorted key table engine: predicts each result and compares it.
`timescale 1ns / 100ps

module sorted_key_table_engine_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          errors,
   output int          results_due,
   output int          table_used
);
   import skt_pkg::*;

   typedef struct packed {
      logic [15:0] key;
      logic        mark;
      logic [15:0] disk;
      logic [15:0] rec;
   } table_slot_type;

   table_slot_type slots [Depth];
   logic [23:0]    due_results [$];
   int             used;

   assign table_used  = used;

   // Shift entries down over a removed range, with the same saturation as the block.
   function automatic void drop_range(int at, int n);
      if (at > used) at = used;
      if (n > used - at) n = used - at;
      for (int i = at; i + n < used; i++) slots[i] = slots[i + n];
      used -= n;
   endfunction

   // Work out the state change and the result for one request.
   function automatic logic [23:0] apply_request(logic [71:0] d);
      logic [2:0]  fn;
      logic [15:0] key;
      int          idx, cnt, lo, hi, mid, at;
      logic        hit, above, status, removed;
      logic [9:0]  pos;
      fn      = d[2:0];
      key     = d[18:3];
      idx     = d[28:19];
      cnt     = d[38:29];
      hit     = 1'b0;
      status  = 1'b0;
      removed = 1'b0;
      pos     = '0;
      case (fn)
         FUNC_SEARCH: begin
            lo    = 0;
            hi    = used - 1;
            mid   = 0;
            above = 1'b0;
            while (lo <= hi && !hit) begin
               above = 1'b0;
               mid   = (lo + hi) / 2;
               if (key == slots[mid].key) begin
                  hit = 1'b1;
               end else if (key > slots[mid].key) begin
                  above = 1'b1;
                  lo    = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
            if (above) mid++;
            pos = mid[9:0];
         end
         FUNC_GAP: begin
            if (used + cnt > Depth) begin
               status = 1'b1;
            end else begin
               at = (idx > used) ? used : idx;
               for (int i = used - 1; i >= at; i--) slots[i + cnt] = slots[i];
               used += cnt;
            end
         end
         FUNC_REMOVE: drop_range(idx, cnt);
         FUNC_EMPTY: begin
            if (idx < used && !slots[idx].mark && slots[idx].disk == DiskNil &&
                slots[idx].rec == RecordNil) begin
               drop_range(idx, 1);
               removed = 1'b1;
            end
         end
         FUNC_WRITE: begin
            if (idx < Depth) slots[idx] = {key, d[39], d[55:40], d[71:56]};
         end
         default: ;
      endcase
      return {1'b0, used[9:0], removed, status, pos, hit};
   endfunction

   // Compare one field and report the first few mismatches.
   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         if (errors <= 10)
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Results are handled before requests: a result in the same cycle is an older one.
   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         errors = 0;
         used   = 0;
         due_results.delete();
         foreach (slots[i]) slots[i] = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("result transfer with nothing outstanding: %h",
                                          rsp_tdata);
            end else begin
               want = due_results.pop_front();
               check_field("found", want[0], rsp_tdata[0]);
               check_field("position", want[10:1], rsp_tdata[10:1]);
               check_field("status", want[11], rsp_tdata[11]);
               check_field("removed", want[12], rsp_tdata[12]);
               check_field("used_count", want[22:13], rsp_tdata[22:13]);
            end
         end
         if (req_tvalid && req_tready) due_results.push_back(apply_request(req_tdata));
      end
      results_due = due_results.size();
   end

endmodule

// ===== tb/sv/sorted_key_table_engine_tb.sv =====
// Top of the sorted key table engine testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module sorted_key_table_engine_tb;
   import skt_pkg::*;

   localparam int StallLimit = 8000;
   localparam int ItemTarget = 1000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   int          errors;
   int          results_due;
   int          table_used;
   int          sent;
   int          op_tally [8];
   int          fill_words;
   int          idle_run;
   int          results_taken;
   bit          calm;

   sorted_key_table_engine uut (.*);

   sorted_key_table_engine_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .results_due(results_due), .table_used(table_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a long stretch with no transfer on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= StallLimit) begin
            $display("sorted_key_table_engine_tb: done, errors");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold-off to back the block up.
   initial begin
      int pause;
      bit held;
      rsp_tready    = 1'b0;
      results_taken = 0;
      held          = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pause = calm ? 0 : $urandom_range(0, 3);
         if (results_taken == 300 && !held) begin
            pause = 400;
            held  = 1'b1;
         end
         repeat (pause) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_taken++;
      end
   end

   // Offer one request; the contents are chosen at the falling edge it is driven on.
   task automatic offer(logic [2:0] fn, logic [15:0] key, int idx, int cnt, logic mark,
                        logic [15:0] disk, logic [15:0] rec);
      int pause;
      pause = calm ? 0 : $urandom_range(0, 3);
      repeat (pause) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {rec, disk, mark, cnt[9:0], idx[9:0], key, fn};
      do @(posedge clock); while (!req_tready);
      sent++;
      op_tally[fn]++;
   endtask

   // Fill the slots of a freshly opened gap so that nothing unwritten is read later.
   task automatic fill_gap(int at, int cnt);
      for (int i = 0; i < cnt; i++) begin
         offer(FUNC_WRITE, 16'($urandom), at + i, $urandom_range(0, 1023),
               $urandom_range(0, 1), $urandom_range(0, 1) ? DiskNil : 16'($urandom),
               $urandom_range(0, 1) ? RecordNil : 16'($urandom));
         fill_words++;
      end
   endtask

   // Open a gap and fill it when the table has room for it.
   task automatic open_gap(int idx, int cnt);
      int used_then;
      used_then = table_used;
      offer(FUNC_GAP, 16'($urandom), idx, cnt, 1'($urandom), 16'($urandom), 16'($urandom));
      if (used_then + cnt <= Depth) fill_gap((idx > used_then) ? used_then : idx, cnt);
   endtask

   // One random request, weighted towards sequences that keep the table busy.
   task automatic random_request();
      int pick, used_now, idx, cnt;
      logic mark;
      @(negedge clock);
      used_now = table_used;
      pick     = $urandom_range(0, 99);
      if (pick < 28) begin
         offer(FUNC_SEARCH, 16'($urandom), $urandom_range(0, 1023), $urandom_range(0, 1023),
               1'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 43) begin
         cnt = $urandom_range(0, 99);
         cnt = (cnt < 85) ? $urandom_range(1, 4) :
               (cnt < 95) ? $urandom_range(0, 32) : $urandom_range(0, 1023);
         idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
               $urandom_range(0, used_now);
         open_gap(idx, cnt);
      end else if (pick < 53) begin
         cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 1023);
         idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) :
               $urandom_range(0, used_now);
         offer(FUNC_REMOVE, 16'($urandom), idx, cnt, 1'($urandom), 16'($urandom),
               16'($urandom));
      end else if (pick < 68) begin
         idx = (used_now > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, used_now - 1)
               : $urandom_range(used_now, 1023);
         offer(FUNC_EMPTY, 16'($urandom), idx, $urandom_range(0, 1023), 1'($urandom),
               16'($urandom), 16'($urandom));
      end else if (pick < 94) begin
         idx  = (used_now > 0 && $urandom_range(0, 9) < 7) ? $urandom_range(0, used_now - 1)
                : $urandom_range(0, 1023);
         mark = ($urandom_range(0, 9) < 3);
         offer(FUNC_WRITE, 16'($urandom), idx, $urandom_range(0, 1023), mark,
               $urandom_range(0, 1) ? DiskNil : 16'($urandom),
               $urandom_range(0, 1) ? RecordNil : 16'($urandom));
      end else begin
         // Spare function codes above the write operation.
         offer(3'($urandom_range(FUNC_WRITE + 1, 7)), 16'($urandom), $urandom_range(0, 1023),
               $urandom_range(0, 1023), 1'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // Stimulus and verdict.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      sent       = 0;
      fill_words = 0;
      calm       = 1'b0;
      idle_run   = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table: every operation, the spare codes and out-of-range fields.
      offer(FUNC_SEARCH, 16'hFFFF, 0, 0, 1'b0, 16'h0000, 16'h0000);
      offer(FUNC_WRITE, 16'h1234, 1023, 1023, 1'b1, 16'hFFFF, 16'hFFFF);
      open_gap(0, 1023);
      open_gap(1023, 0);
      offer(FUNC_REMOVE, 16'h0000, 1023, 1023, 1'b0, 16'h0000, 16'h0000);
      offer(FUNC_EMPTY, 16'h0000, 0, 0, 1'b0, 16'h0000, 16'h0000);
      offer(3'd5, 16'hFFFF, 1023, 1023, 1'b1, 16'hFFFF, 16'hFFFF);
      offer(3'd6, 16'h0000, 0, 0, 1'b0, 16'h0000, 16'h0000);
      offer(3'd7, 16'hA5A5, 512, 512, 1'b1, 16'h5A5A, 16'hA5A5);
      // Four known entries: keys 0, 100, 200 and the top key.
      offer(FUNC_GAP, 16'h0000, 1023, 4, 1'b0, 16'h0000, 16'h0000);
      offer(FUNC_WRITE, 16'd0, 0, 0, 1'b0, DiskNil, RecordNil);
      offer(FUNC_WRITE, 16'd100, 1, 0, 1'b1, DiskNil, RecordNil);
      offer(FUNC_WRITE, 16'd200, 2, 0, 1'b0, 16'h0000, RecordNil);
      offer(FUNC_WRITE, 16'hFFFF, 3, 0, 1'b0, DiskNil, 16'h0000);
      offer(FUNC_SEARCH, 16'd0, 0, 0, 1'b0, 0, 0);
      offer(FUNC_SEARCH, 16'hFFFF, 0, 0, 1'b0, 0, 0);
      offer(FUNC_SEARCH, 16'd150, 0, 0, 1'b0, 0, 0);
      offer(FUNC_SEARCH, 16'd50, 0, 0, 1'b0, 0, 0);
      // Marked entry stays, linked entry stays, clear entry goes, past the end does nothing.
      offer(FUNC_EMPTY, 16'd0, 1, 0, 1'b0, 0, 0);
      offer(FUNC_EMPTY, 16'd0, 2, 0, 1'b0, 0, 0);
      offer(FUNC_EMPTY, 16'd0, 0, 0, 1'b0, 0, 0);
      offer(FUNC_EMPTY, 16'd0, 3, 0, 1'b0, 0, 0);
      offer(FUNC_WRITE, 16'h7777, 511, 0, 1'b1, 16'h0001, 16'h0002);
      // Fill to capacity, refuse one more, then clear with an oversized removal.
      @(negedge clock);
      open_gap(1, Depth - table_used);
      open_gap(0, 1);
      offer(FUNC_REMOVE, 16'h0000, 0, 1023, 1'b0, 0, 0);

      // Random part, switching now and then into a stretch without idle cycles.
      while (sent < ItemTarget) begin
         if ($urandom_range(0, 99) == 0) calm = ~calm;
         random_request();
      end
      calm = 1'b0;
      @(negedge clock);
      req_tvalid = 1'b0;

      while (results_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d requests (%0d gap fills): search %0d, gap %0d, remove %0d,",
               sent, fill_words, op_tally[0], op_tally[1], op_tally[2]);
      $display("  empty check %0d, write %0d, spare codes %0d, results taken %0d",
               op_tally[3], op_tally[4], op_tally[5] + op_tally[6] + op_tally[7],
               results_taken);
      if (errors == 0) begin
         $display("sorted_key_table_engine_tb: done, clean");
      end else begin
         $display("sorted_key_table_engine_tb: done, errors");
      end
      $finish;
   end

endmodule
